>>> src/acu_pkg.sv
// Shared types, constants and a helper function for the ARP cache with use-count replacement.
// No dependencies.
package acu_pkg;

   localparam int CACHE_ENTRIES = 8;
   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam int IP_W = 32;
   localparam int MAC_W = 48;
   localparam int USE_W = 8;
   localparam int SLOT_W = 3;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_FILL = 1'b1;

   localparam logic [USE_W-1:0] COUNT_MAX = 8'd255;
   localparam logic [USE_W-1:0] COUNT_INC = 8'd2;
   localparam logic [USE_W-1:0] COUNT_FILL = 8'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [IP_W-1:0] ip;
      logic [MAC_W-1:0] mac;
   } entry_type;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = (IDX_W + SLOT_W)'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage

>>> src/acu_req_if.sv
// Request channel of the ARP cache: valid, ready and the request payload.
// Depends on acu_pkg.
interface acu_req_if;
   import acu_pkg::*;

   logic valid;
   logic ready;
   logic kind;
   logic [IP_W-1:0] ip_addr;
   logic [MAC_W-1:0] mac_addr;

   modport source (output valid, output kind, output ip_addr, output mac_addr, input ready);
   modport sink (input valid, input kind, input ip_addr, input mac_addr, output ready);

endinterface

>>> src/acu_rsp_if.sv
// Response channel of the ARP cache: valid, ready and the response payload.
// Depends on acu_pkg.
interface acu_rsp_if;
   import acu_pkg::*;

   logic valid;
   logic ready;
   logic hit;
   logic [MAC_W-1:0] found_mac;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, output hit, output found_mac, output slot, input ready);
   modport sink (input valid, input hit, input found_mac, input slot, output ready);

endinterface

>>> src/arp_cache_use_count_replace_top.sv
// Top level of the ARP cache with use-count replacement.
// Depends on acu_pkg, acu_req_if and acu_rsp_if.
// A lookup walks the entry and count memories one entry per cycle, then loads its response;
// a fill reads the victim's count, then writes the entry and count back. A new request is
// accepted only in the idle state, once the previous response is loaded into the output register.
// Reset clears the state machine, the entry valid bits, the victim slot and the response valid; no clearing pass.
module arp_cache_use_count_replace_top (
   input logic clock,
   input logic reset,
   acu_req_if.sink req_chan,
   acu_rsp_if.source rsp_chan
);
   import acu_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] NUM_ENTRIES = CNT_W'(CACHE_ENTRIES);

   state_type state_ff, state_in;

   entry_type ent_mem [CACHE_ENTRIES];
   logic [USE_W-1:0] cnt_mem [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] vld_ff;

   entry_type ent_rd_ff;
   logic [USE_W-1:0] cnt_rd_ff;
   logic cnt_vld_rd_ff;

   logic [IP_W-1:0] req_ip_ff, req_ip_in;
   logic [MAC_W-1:0] req_mac_ff, req_mac_in;
   logic [CNT_W-1:0] issue_idx_ff, issue_idx_in;
   logic [IDX_W-1:0] proc_idx_ff, proc_idx_in;
   logic pv_ff, pv_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [MAC_W-1:0] hit_mac_ff, hit_mac_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [USE_W-1:0] best_cnt_ff, best_cnt_in;
   logic [IDX_W-1:0] victim_ff, victim_in;
   logic res_hit_ff, res_hit_in;
   logic [MAC_W-1:0] res_mac_ff, res_mac_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic [MAC_W-1:0] rsp_mac_ff, rsp_mac_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic req_ready;
   logic accept;
   logic rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic wr_en;
   logic ent_we;
   logic [IDX_W-1:0] wr_addr;
   logic [USE_W-1:0] wr_cnt;
   logic load_rsp;

   logic [USE_W-1:0] cur_cnt;
   logic take;
   logic [USE_W-1:0] scan_cnt;
   logic [USE_W-1:0] fill_cnt;
   logic better;

   // Per-entry update of the walk: the first valid match gains two, other live counts lose one.
   always_comb begin
      cur_cnt = cnt_vld_rd_ff ? cnt_rd_ff : '0;
      take = !found_ff && (cur_cnt != '0) && (ent_rd_ff.ip == req_ip_ff);
      if (take) begin
         scan_cnt = (cur_cnt > (COUNT_MAX - COUNT_INC)) ? COUNT_MAX : cur_cnt + COUNT_INC;
      end else if (cur_cnt != '0) begin
         scan_cnt = cur_cnt - 8'd1;
      end else begin
         scan_cnt = '0;
      end
      fill_cnt = (cur_cnt == '0) ? COUNT_FILL : cur_cnt;
      better = (proc_idx_ff == '0) || (scan_cnt < best_cnt_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = (req_chan.kind == KIND_FILL) ? ST_FILL : ST_SCAN;
            end
         end
         ST_FILL: state_in = ST_RESP;
         ST_SCAN: begin
            if (pv_ff && (proc_idx_ff == LAST_IDX)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      accept = 1'b0;
      rd_en = 1'b0;
      rd_addr = issue_idx_ff[IDX_W-1:0];
      wr_en = 1'b0;
      ent_we = 1'b0;
      wr_addr = proc_idx_ff;
      wr_cnt = scan_cnt;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept = req_chan.valid;
            rd_en = req_chan.valid;
            rd_addr = (req_chan.kind == KIND_FILL) ? victim_ff : '0;
         end
         ST_FILL: begin
            wr_en = 1'b1;
            ent_we = 1'b1;
            wr_addr = victim_ff;
            wr_cnt = fill_cnt;
         end
         ST_SCAN: begin
            rd_en = (issue_idx_ff < NUM_ENTRIES);
            wr_en = pv_ff;
         end
         ST_RESP: begin
            load_rsp = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      logic found_now;
      logic [IDX_W-1:0] hit_idx_now;
      logic [MAC_W-1:0] hit_mac_now;
      logic [IDX_W-1:0] best_idx_now;

      found_now = found_ff || take;
      hit_idx_now = take ? proc_idx_ff : hit_idx_ff;
      hit_mac_now = take ? ent_rd_ff.mac : hit_mac_ff;
      best_idx_now = better ? proc_idx_ff : best_idx_ff;

      req_ip_in = req_ip_ff;
      req_mac_in = req_mac_ff;
      issue_idx_in = issue_idx_ff;
      proc_idx_in = proc_idx_ff;
      pv_in = 1'b0;
      found_in = found_ff;
      hit_idx_in = hit_idx_ff;
      hit_mac_in = hit_mac_ff;
      best_idx_in = best_idx_ff;
      best_cnt_in = best_cnt_ff;
      victim_in = victim_ff;
      res_hit_in = res_hit_ff;
      res_mac_in = res_mac_ff;
      res_slot_in = res_slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_mac_in = rsp_mac_ff;
      rsp_slot_in = rsp_slot_ff;

      if (accept) begin
         req_ip_in = req_chan.ip_addr;
         req_mac_in = req_chan.mac_addr;
         issue_idx_in = CNT_W'(1);
         proc_idx_in = '0;
         pv_in = (req_chan.kind == KIND_LOOKUP);
         found_in = 1'b0;
         best_idx_in = '0;
         best_cnt_in = COUNT_MAX;
      end

      if (state_ff == ST_SCAN) begin
         if (rd_en) begin
            pv_in = 1'b1;
            proc_idx_in = issue_idx_ff[IDX_W-1:0];
            issue_idx_in = issue_idx_ff + CNT_W'(1);
         end
         if (pv_ff) begin
            found_in = found_now;
            hit_idx_in = hit_idx_now;
            hit_mac_in = hit_mac_now;
            best_idx_in = best_idx_now;
            if (better) begin
               best_cnt_in = scan_cnt;
            end
            if (proc_idx_ff == LAST_IDX) begin
               res_hit_in = found_now;
               if (found_now) begin
                  res_mac_in = hit_mac_now;
                  res_slot_in = slot_of(hit_idx_now);
               end else begin
                  res_mac_in = '0;
                  res_slot_in = slot_of(best_idx_now);
                  victim_in = best_idx_now;
               end
            end
         end
      end

      if (state_ff == ST_FILL) begin
         res_hit_in = 1'b0;
         res_mac_in = '0;
         res_slot_in = slot_of(victim_ff);
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in = res_hit_ff;
         rsp_mac_in = res_mac_ff;
         rsp_slot_in = res_slot_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff <= 1'b0;
         victim_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff <= pv_in;
         victim_ff <= victim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ip_ff <= req_ip_in;
      req_mac_ff <= req_mac_in;
      issue_idx_ff <= issue_idx_in;
      proc_idx_ff <= proc_idx_in;
      found_ff <= found_in;
      hit_idx_ff <= hit_idx_in;
      hit_mac_ff <= hit_mac_in;
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
      res_hit_ff <= res_hit_in;
      res_mac_ff <= res_mac_in;
      res_slot_ff <= res_slot_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_mac_ff <= rsp_mac_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[victim_ff] <= {req_ip_ff, req_mac_ff};
      end
      if (wr_en) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
      if (rd_en) begin
         ent_rd_ff <= ent_mem[rd_addr];
         cnt_rd_ff <= cnt_mem[rd_addr];
         cnt_vld_rd_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hit = rsp_hit_ff;
   assign rsp_chan.found_mac = rsp_mac_ff;
   assign rsp_chan.slot = rsp_slot_ff;

endmodule
